### rtl/signed_int_to_radix_text_top_defines.svh
// ----------------------------------------------------------------------------
// signed_int_to_radix_text_top_defines
// assertion macros for the radix text converter rtl, used by sirt_back
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_RADIX_TEXT_TOP_DEFINES_SVH
`define SIGNED_INT_TO_RADIX_TEXT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold on every enabled clock edge
`define SIRT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define SIRT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define SIRT_ASSERT(label, clk, rst_n, prop, msg)
`define SIRT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/sirt_pkg.sv
// ----------------------------------------------------------------------------
// sirt_pkg
// types, constants and the digit character lookup of the radix text converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sirt_pkg;

  localparam int ValueW    = 32;
  localparam int DigitW    = 4;
  localparam int CharW     = 8;
  localparam int CfgDataW  = 64;
  localparam int CfgIndexW = 2;
  localparam int MaxDigits = 32;
  localparam int CntW      = $clog2(MaxDigits + 1);
  localparam int SliceW    = 8;
  localparam int StepW     = $clog2(ValueW / SliceW);

  localparam logic [CharW-1:0]    MinusChar      = 8'h2D;
  localparam logic [4:0]          RadixReset     = 5'd10;
  localparam logic [CfgDataW-1:0] CharsLowReset  = 64'h3736_3534_3332_3130;
  localparam logic [CfgDataW-1:0] CharsHighReset = 64'h4645_4443_4241_3938;

  localparam logic [CfgIndexW-1:0] CfgRadix     = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgCharsLow  = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgCharsHigh = 2'd2;

  typedef struct packed {
    logic              neg;
    logic [ValueW-1:0] mag;
  } sirt_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SIGN,
    BK_EMIT
  } sirt_back_state_t;

  function automatic logic [CharW-1:0] digit_char(
    input logic [CfgDataW-1:0] chars_low,
    input logic [CfgDataW-1:0] chars_high,
    input logic [DigitW-1:0]   d
  );
    logic [CfgDataW-1:0] sel;
    sel = d[3] ? chars_high : chars_low;
    return sel[{d[2:0], 3'b000} +: CharW];
  endfunction

endpackage

### rtl/sirt_in_if.sv
// ----------------------------------------------------------------------------
// sirt_in_if
// request channel carrying one signed value to convert
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sirt_in_if import sirt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

### rtl/sirt_out_if.sv
// ----------------------------------------------------------------------------
// sirt_out_if
// result channel carrying one text character per transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sirt_out_if import sirt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;
  logic             last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink (input valid, input character, input last_char, output ready);
endinterface

### rtl/sirt_front.sv
// ----------------------------------------------------------------------------
// sirt_front
// accepts values, splits sign and magnitude, drops values for a bad radix
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sirt_front import sirt_pkg::*; #(
  parameter int MAX_BASE = 16
) (
  sirt_in_if.sink    in_ch,
  input  logic [4:0] radix,
  output logic       push_valid,
  input  logic       push_ready,
  output sirt_job_t  push_job
);

  logic              radix_ok;
  logic [ValueW-1:0] raw;

  assign raw      = $unsigned(in_ch.value);
  assign radix_ok = (radix >= 5'd2) && (radix <= 5'(MAX_BASE));

  assign in_ch.ready   = push_ready;
  assign push_valid    = in_ch.valid && radix_ok;
  assign push_job.neg  = raw[ValueW-1];
  assign push_job.mag  = raw[ValueW-1] ? (ValueW'(0) - raw) : raw;

endmodule

### rtl/sirt_queue.sv
// ----------------------------------------------------------------------------
// sirt_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sirt_queue import sirt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  sirt_job_t push_job,
  output logic      pop_valid,
  input  logic      pop_ready,
  output sirt_job_t pop_job
);

  sirt_job_t  entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_job    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### rtl/sirt_back.sv
// ----------------------------------------------------------------------------
// sirt_back
// divides the magnitude down into digits, then sends sign and digit characters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sirt_back import sirt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [4:0]          radix,
  input  logic [CfgDataW-1:0] chars_low,
  input  logic [CfgDataW-1:0] chars_high,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  sirt_job_t           pop_job,
  sirt_out_if.source          out_ch
);

  `include "signed_int_to_radix_text_top_defines.svh"

  sirt_back_state_t  state_r, state_nxt;
  logic [ValueW-1:0] work_r, work_nxt;
  logic [DigitW-1:0] rem_r, rem_nxt;
  logic [StepW-1:0]  step_r, step_nxt;
  logic [CntW-1:0]   nd_r, nd_nxt;
  logic              neg_r, neg_nxt;
  logic [DigitW-1:0] digit_r [MaxDigits];
  logic              out_valid_r, out_valid_nxt;
  logic [CharW-1:0]  out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  logic              slot_free;
  logic              push_digit;
  logic [ValueW-1:0] work_div;
  logic [DigitW-1:0] rem_div;
  logic [$clog2(MaxDigits)-1:0] rd_idx;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last_char = out_last_r;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign rd_idx    = $clog2(MaxDigits)'(nd_r - CntW'(1));

  // one slice of the long division by the radix
  always_comb begin
    logic [4:0]        r;
    logic [ValueW-1:0] w;
    r = {1'b0, rem_r};
    w = work_r;
    for (int i = 0; i < SliceW; i++) begin
      r = {r[3:0], w[ValueW-1]};
      w = {w[ValueW-2:0], 1'b0};
      if (r >= radix) begin
        r    = r - radix;
        w[0] = 1'b1;
      end
    end
    rem_div  = r[DigitW-1:0];
    work_div = w;
  end

  always_comb begin
    state_nxt     = state_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    nd_nxt        = nd_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    pop_ready     = 1'b0;
    push_digit    = 1'b0;

    case (state_r)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          work_nxt  = pop_job.mag;
          neg_nxt   = pop_job.neg;
          rem_nxt   = '0;
          step_nxt  = '0;
          nd_nxt    = '0;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        work_nxt = work_div;
        rem_nxt  = rem_div;
        step_nxt = step_r + StepW'(1);
        if (step_r == '1) begin
          push_digit = 1'b1;
          nd_nxt     = nd_r + CntW'(1);
          rem_nxt    = '0;
          if (work_div == '0 || nd_r == CntW'(MaxDigits - 1)) begin
            state_nxt = neg_r ? BK_SIGN : BK_EMIT;
          end
        end
      end
      BK_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = MinusChar;
          out_last_nxt  = 1'b0;
          state_nxt     = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(chars_low, chars_high, digit_r[rd_idx]);
          out_last_nxt  = (nd_r == CntW'(1));
          nd_nxt        = nd_r - CntW'(1);
          if (nd_r == CntW'(1)) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      nd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nd_r        <= nd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r     <= work_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (push_digit) begin
      digit_r[nd_r[$clog2(MaxDigits)-1:0]] <= rem_div;
    end
  end

  `SIRT_ASSERT(a_nd_bound, clk, rst_n, nd_r <= CntW'(MaxDigits), "digit count overflow")
  `SIRT_ASSERT_IMPL(a_emit_nonempty, clk, rst_n, state_r == BK_EMIT, nd_r != '0, "emit with no digits")
  `SIRT_ASSERT_IMPL(a_idle_drained, clk, rst_n, state_r == BK_IDLE, nd_r == '0, "digits left at idle")
  `SIRT_ASSERT_IMPL(a_digit_range, clk, rst_n, push_digit, 5'(rem_div) < radix, "digit too big")

endmodule

### rtl/signed_int_to_radix_text_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_radix_text_top
// Converts each signed 32-bit request into its text in the configured base
// (2 to MAX_BASE), one character per result, most significant digit first,
// with a leading minus for negative values and last_char on the final
// character. A value is dropped without output while radix is out of range.
// The back end divides the magnitude by the radix eight bits per cycle,
// digit by digit, then sends the characters, holding each one while the
// result side is not ready. A two-entry queue lets new requests be taken
// while the back end is busy. Configuration registers: 0 radix, 1 and 2 the
// digit characters for values 0-7 and 8-15, lowest byte first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_int_to_radix_text_top import sirt_pkg::*; #(
  parameter int MAX_BASE = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sirt_in_if.sink              in_ch,
  sirt_out_if.source           out_ch,
  input  logic                 cfg_wr_en,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  logic [4:0]          radix_r, radix_nxt;
  logic [CfgDataW-1:0] chars_low_r, chars_low_nxt;
  logic [CfgDataW-1:0] chars_high_r, chars_high_nxt;

  logic      push_valid, push_ready;
  sirt_job_t push_job;
  logic      pop_valid, pop_ready;
  sirt_job_t pop_job;

  always_comb begin
    radix_nxt      = radix_r;
    chars_low_nxt  = chars_low_r;
    chars_high_nxt = chars_high_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CfgRadix:     radix_nxt      = cfg_data[4:0];
        CfgCharsLow:  chars_low_nxt  = cfg_data;
        CfgCharsHigh: chars_high_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r      <= RadixReset;
      chars_low_r  <= CharsLowReset;
      chars_high_r <= CharsHighReset;
    end else begin
      radix_r      <= radix_nxt;
      chars_low_r  <= chars_low_nxt;
      chars_high_r <= chars_high_nxt;
    end
  end

  sirt_front #(
    .MAX_BASE (MAX_BASE)
  ) u_front (
    .in_ch      (in_ch),
    .radix      (radix_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  sirt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  sirt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .radix      (radix_r),
    .chars_low  (chars_low_r),
    .chars_high (chars_high_r),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job),
    .out_ch     (out_ch)
  );

endmodule

### dv/sirt_text_checker.sv
// ----------------------------------------------------------------------------
// sirt_text_checker
// Watches the request, result and configuration ports of the radix text
// converter. It keeps its own copy of the radix and the digit character
// table, turns each accepted request into the characters it must produce, and
// compares every accepted result against the oldest of them, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sirt_text_checker import sirt_pkg::*; #(
  parameter int MAX_BASE = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sirt_in_if                   in_mon,
  sirt_out_if                  out_mon,
  input  logic                 cfg_wr_en,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  output int                   fail_count,
  output int                   pending_chars
);

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             last_char;
  } text_char_t;

  text_char_t          expected_text_q[$];
  logic [4:0]          radix_reg;
  logic [CfgDataW-1:0] chars_lo;
  logic [CfgDataW-1:0] chars_hi;

  task automatic queue_text(input logic signed [ValueW-1:0] value);
    logic [ValueW-1:0]     mag;
    logic [DigitW-1:0]     digits[MaxDigits];
    logic [2*CfgDataW-1:0] char_map;
    int                    count;
    if (radix_reg < 2 || radix_reg > MAX_BASE) return;
    char_map = {chars_hi, chars_lo};
    mag = value[ValueW-1] ? (~value + 1'b1) : value;
    count = 0;
    do begin
      digits[count] = DigitW'(mag % radix_reg);
      count++;
      mag = mag / radix_reg;
    end while (mag != 0 && count < MaxDigits);
    if (value[ValueW-1]) expected_text_q.push_back('{MinusChar, 1'b0});
    for (int i = count - 1; i >= 0; i--) begin
      expected_text_q.push_back('{char_map[{digits[i], 3'b000} +: CharW], i == 0});
    end
  endtask

  always @(posedge clk) begin
    text_char_t want;
    if (!rst_n) begin
      radix_reg     <= RadixReset;
      chars_lo      <= CharsLowReset;
      chars_hi      <= CharsHighReset;
      fail_count    <= 0;
      pending_chars <= 0;
      expected_text_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CfgRadix:     radix_reg <= cfg_data[4:0];
          CfgCharsLow:  chars_lo  <= cfg_data;
          CfgCharsHigh: chars_hi  <= cfg_data;
          default: ;
        endcase
      end
      // results first, so a request never meets its own characters on one edge
      if (out_mon.valid && out_mon.ready) begin
        if (expected_text_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual char %h last %b",
                   $time, out_mon.character, out_mon.last_char);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_text_q.pop_front();
          if (out_mon.character !== want.character ||
              out_mon.last_char !== want.last_char) begin
            if (out_mon.character !== want.character)
              $display("%0t: character mismatch: expected %h actual %h",
                       $time, want.character, out_mon.character);
            if (out_mon.last_char !== want.last_char)
              $display("%0t: last_char mismatch: expected %b actual %b",
                       $time, want.last_char, out_mon.last_char);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) queue_text(in_mon.value);
      pending_chars <= expected_text_q.size();
    end
  end

endmodule

### dv/signed_int_to_radix_text_top_tb.sv
// ----------------------------------------------------------------------------
// signed_int_to_radix_text_top_tb
// Drives signed values into the radix text converter under a series of radix
// and digit table settings, legal and illegal, with random gaps on the
// request side and random stalls on the result side. Checking is done by the
// text checker next to the block; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_int_to_radix_text_top_tb;
  import sirt_pkg::*;

  localparam logic [CfgIndexW-1:0] CfgSpare = 2'd3;
  localparam int MaxBase      = 16;
  localparam int SettleCycles = 400;
  localparam int QuietLimit   = 4000;
  localparam int RandomItems  = 70;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;
  int                   fails;
  int                   pending;
  int                   quiet_cycles;
  int                   ready_hold;
  int                   random_sent;
  bit                   idle_on;
  logic [4:0]           cur_radix;

  sirt_in_if  in_if ();
  sirt_out_if out_if ();

  signed_int_to_radix_text_top #(.MAX_BASE(MaxBase)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sirt_text_checker #(.MAX_BASE(MaxBase)) text_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fails),
    .pending_chars (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // result side drops ready in random bursts while idle_on is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      ready_hold   <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_if.ready <= 1'b0;
      ready_hold   <= $urandom_range(0, 10);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic push_value(input logic signed [ValueW-1:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk); while (!in_if.ready);
    if (cur_radix >= 2 && cur_radix <= MaxBase) random_sent++;
  endtask

  // no request in flight and no character outstanding
  task automatic wait_until_quiet();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CfgRadix) cur_radix = data[4:0];
    @(posedge clk);
  endtask

  // radix value in bits 4:0, junk above it
  task automatic write_radix(input logic [4:0] r);
    logic [CfgDataW-1:0] d;
    d      = {$urandom, $urandom};
    d[4:0] = r;
    write_cfg(CfgRadix, d);
  endtask

  function automatic logic [4:0] pick_radix();
    int r;
    case ($urandom_range(0, 9))
      0: return 5'd2;
      1: return 5'd16;
      2: begin
        r = $urandom_range(0, 16);
        return (r < 2) ? 5'(r) : 5'(r + 15);
      end
      default: return 5'($urandom_range(2, 16));
    endcase
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return ValueW'($urandom_range(0, 40));
      1: return ValueW'(0 - $urandom_range(1, 40));
      2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    rst_n       = 1'b0;
    idle_on     = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = CfgRadix;
    cfg_data    = '0;
    in_if.valid = 1'b0;
    in_if.value = '0;
    cur_radix   = RadixReset;
    random_sent = 0;
    repeat (6) @(posedge clk);
    rst_n   <= 1'b1;
    idle_on = 1'b1;

    // reset table and base ten
    push_value(0);
    push_value(1);
    push_value(-1);
    push_value(9);
    push_value(10);
    push_value(32'sh7FFF_FFFF);
    push_value(32'sh8000_0000);
    push_value(12345);
    push_value(-987);

    // base two, longest texts
    wait_until_quiet();
    write_radix(5'd2);
    cfg_wr_en <= 1'b0;
    push_value(32'sh8000_0000);
    push_value(32'sh7FFF_FFFF);
    push_value(-1);
    push_value(32'sh5555_5555);
    push_value(32'shAAAA_AAAA);

    // base sixteen with a lowercase table, ignored index on the side
    wait_until_quiet();
    write_radix(5'd16);
    write_cfg(CfgCharsHigh, 64'h6665_6463_6261_3938);
    write_cfg(CfgSpare, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_wr_en <= 1'b0;
    push_value(32'sh1234_5678);
    push_value(32'shDEAD_BEEF);
    push_value(0);

    // out of range bases drop the request
    wait_until_quiet();
    write_radix(5'd31);
    cfg_wr_en <= 1'b0;
    push_value(77);
    push_value(-77);
    wait_until_quiet();
    write_radix(5'd1);
    cfg_wr_en <= 1'b0;
    push_value(5);
    wait_until_quiet();
    write_radix(5'd17);
    cfg_wr_en <= 1'b0;
    push_value(-5);

    random_sent = 0;
    while (random_sent < RandomItems) begin
      wait_until_quiet();
      write_radix(pick_radix());
      if ($urandom_range(0, 2) == 0) write_cfg(CfgCharsLow, {$urandom, $urandom});
      if ($urandom_range(0, 2) == 0) write_cfg(CfgCharsHigh, {$urandom, $urandom});
      if ($urandom_range(0, 5) == 0) write_cfg(CfgSpare, {$urandom, $urandom});
      cfg_wr_en <= 1'b0;
      idle_on = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(4, 14)) push_value(pick_value());
    end

    // closing stretch at full rate
    wait_until_quiet();
    idle_on = 1'b0;
    write_radix(5'd10);
    write_cfg(CfgCharsLow, CharsLowReset);
    write_cfg(CfgCharsHigh, CharsHighReset);
    cfg_wr_en <= 1'b0;
    repeat (8) push_value(pick_value());

    wait_until_quiet();
    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/sirt_pkg.sv
rtl/sirt_in_if.sv
rtl/sirt_out_if.sv
rtl/sirt_front.sv
rtl/sirt_queue.sv
rtl/sirt_back.sv
rtl/signed_int_to_radix_text_top.sv
dv/sirt_text_checker.sv
dv/signed_int_to_radix_text_top_tb.sv
